/* design/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants for the scan block carry unit
// Transfer structs for the item and result channels, the configuration
// struct, element type codes and register indexes.
// ----------------------------------------------------------------------------
package sbc_pkg;

    // Element type codes
    localparam logic [1:0] ETYPE_S32 = 2'd0;
    localparam logic [1:0] ETYPE_U32 = 2'd1;
    localparam logic [1:0] ETYPE_S64 = 2'd2;
    localparam logic [1:0] ETYPE_U64 = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_ELEMENT_TYPE   = 1'b0;
    localparam logic REG_INCLUSIVE_MODE = 1'b1;

    localparam int unsigned DATA_W = 64;

    typedef struct packed {
        logic [5:0]        block_number;
        logic [DATA_W-1:0] first_output;
        logic [DATA_W-1:0] last_output;
        logic [DATA_W-1:0] last_input;
    } item_t;

    typedef struct packed {
        logic [5:0]        block_echo;
        logic [DATA_W-1:0] original_value;
        logic [DATA_W-1:0] injected_value;
        logic              status;
    } result_t;

    typedef struct packed {
        logic [1:0] element_type;
        logic       inclusive_mode;
    } cfg_t;

    // Result of an overflow-checked add
    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] value;
    } add_res_t;

endpackage

/* design/scan_block_carry_checked.sv */
// ----------------------------------------------------------------------------
// scan_block_carry_checked: carry propagation between scan blocks
// One item per block of a blocked prefix sum; returns the value to keep and
// the value to inject into the block's first element, overflow-checked.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries one block descriptor;
//   result channel (result_valid/result_ready/result) returns one result per
//   item, in order. The APB port sets element_type (0x0) and inclusive_mode
//   (0x4); write it only while no item is in flight.
// Pipeline: an accepted item passes through the input stage and the result
//   stage (two register stages) before it appears on the result port.
// Throughput: one item per cycle while result_ready is high; the carry loop
//   goes from the carry register through two 64-bit checked adds back into it.
// Reset: carry clears to zero, element_type to signed 32-bit, inclusive_mode
//   to 1; both stages empty.
// Stall: while result_ready is low the result register holds; the input
//   stage still takes one more item, then item_ready drops until the result
//   is transferred.
// ----------------------------------------------------------------------------
module scan_block_carry_checked
    import sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_load;
    logic    advance;
    logic    accept;

    sbc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbc_carry_unit u_carry (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (stage_item_reg),
        .commit (advance),
        .result (result_next)
    );

    // Handshake
    assign result_load = !result_valid_reg || result_ready;
    assign advance     = stage_valid_reg && result_load;
    assign item_ready  = !stage_valid_reg || result_load;
    assign accept      = item_valid && item_ready;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (advance)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= item;
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_load)
            result_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Overflow results carry zero values
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |->
            result.original_value == '0 && result.injected_value == '0)
        else $error("nonzero values on overflow result");

    // A staged item that cannot move stays staged
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !result_load |=> stage_valid_reg)
        else $error("staged item dropped");

    // Empty input stage always takes a transfer
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> item_ready)
        else $error("input stalled while empty");

endmodule

/* design/sbc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sbc_cfg_regs: APB configuration registers
// Holds element_type (offset 0x0) and inclusive_mode (offset 0x4).
// Zero wait state; reads return the current register value.
// ----------------------------------------------------------------------------
module sbc_cfg_regs
    import sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_ELEMENT_TYPE:   cfg_next.element_type   = pwdata[1:0];
                REG_INCLUSIVE_MODE: cfg_next.inclusive_mode = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.element_type   <= ETYPE_S32;
            cfg_reg.inclusive_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_ELEMENT_TYPE:   prdata = {30'd0, cfg_reg.element_type};
            REG_INCLUSIVE_MODE: prdata = {31'd0, cfg_reg.inclusive_mode};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* design/sbc_carry_unit.sv */
// ----------------------------------------------------------------------------
// sbc_carry_unit: running carry and checked adds
// Computes original/injected values for one block from the staged item and
// advances the running carry when the item moves to the result register without overflow.
// ----------------------------------------------------------------------------
module sbc_carry_unit
    import sbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    commit,
    output result_t result
);

    logic [DATA_W-1:0] carry_reg;
    logic [DATA_W-1:0] carry_next;
    logic              narrow;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] prior;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] last_out;
    logic [DATA_W-1:0] last_in;
    add_res_t          add_a;
    add_res_t          add_b;
    logic [DATA_W-1:0] original;
    logic [DATA_W-1:0] injected;
    logic [DATA_W-1:0] total;
    logic              ok;

    // Add in the configured element type, flag overflow
    function automatic add_res_t checked_add(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b,
                                             input logic [1:0]        etype);
        logic [DATA_W:0] sum;
        add_res_t        r;
        sum     = {1'b0, a} + {1'b0, b};
        r.value = sum[DATA_W-1:0];
        r.ovf   = 1'b0;
        case (etype)
            ETYPE_S32:
            begin
                r.value = {32'd0, sum[31:0]};
                r.ovf   = (a[31] == b[31]) && (sum[31] != a[31]);
            end
            ETYPE_U32: r.ovf = sum[32];
            ETYPE_S64: r.ovf = (a[63] == b[63]) && (sum[63] != a[63]);
            default:   r.ovf = sum[DATA_W];
        endcase
        return r;
    endfunction

    // Operand masking for 32-bit types
    assign narrow   = (cfg.element_type == ETYPE_S32) || (cfg.element_type == ETYPE_U32);
    assign mask     = narrow ? {32'd0, 32'hFFFF_FFFF} : {DATA_W{1'b1}};
    assign prior    = carry_reg & mask;
    assign first    = item.first_output & mask;
    assign last_out = item.last_output & mask;
    assign last_in  = item.last_input & mask;

    // First add: block total (exclusive) or injected value (inclusive)
    always_comb
    begin
        if (cfg.inclusive_mode)
        begin
            add_a    = checked_add(first, prior, cfg.element_type);
            original = first;
            injected = add_a.value;
            total    = last_out;
        end
        else
        begin
            add_a    = checked_add(last_out, last_in, cfg.element_type);
            original = '0;
            injected = prior;
            total    = add_a.value;
        end
    end

    // Second add: carry advance
    assign add_b = checked_add(prior, total, cfg.element_type);
    assign ok    = !add_a.ovf && !add_b.ovf;

    assign result.block_echo     = item.block_number;
    assign result.original_value = ok ? original : '0;
    assign result.injected_value = ok ? injected : '0;
    assign result.status         = !ok;

    // Narrow types keep the upper half of the carry
    always_comb
    begin
        carry_next = carry_reg;
        if (commit && ok)
        begin
            if (narrow)
                carry_next = {carry_reg[63:32], add_b.value[31:0]};
            else
                carry_next = add_b.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carry_reg <= '0;
        else
            carry_reg <= carry_next;
    end

    // Overflow leaves the carry alone
    a_ovf_holds_carry: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !ok |=> carry_reg == $past(carry_reg))
        else $error("carry changed on overflow");

    // Narrow types never touch the upper carry half
    a_narrow_upper: assert property (@(posedge clk) disable iff (!rst_n)
        narrow |=> carry_reg[63:32] == $past(carry_reg[63:32]))
        else $error("upper carry half changed in 32-bit mode");

    // No commit, no carry change
    a_idle_carry: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(carry_reg))
        else $error("carry changed without commit");

endmodule
